// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/smc_pkg.sv =====
`default_nettype none

package smc_pkg;

	// Default field widths.
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int TIME_BITS_DEF   = 32;

	// Configuration port.
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DRY_READING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WET_READING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRY_DELAY   = 2'd2;

	// Register reset values.
	localparam int DRY_READING_RESET = 4095;
	localparam logic [CFG_W-1:0] DRY_DELAY_RESET = 32'd5000;

	// Result widths.
	localparam int PCT_W  = 7;
	localparam int COND_W = 3;

	// Quotient bits produced by the divider.
	localparam int QUOT_W = 9;

	// Percentage constants and band limits.
	localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;
	localparam logic [PCT_W-1:0] PCT_ZERO      = 7'd0;
	localparam logic [PCT_W-1:0] PCT_VERY_DRY  = 7'd10;
	localparam logic [PCT_W-1:0] PCT_DRY       = 7'd30;
	localparam logic [PCT_W-1:0] PCT_IDLE_MAX  = 7'd40;
	localparam logic [PCT_W-1:0] PCT_MOIST_MAX = 7'd60;
	localparam logic [PCT_W-1:0] PCT_WET_MAX   = 7'd90;

	// Condition codes.
	localparam logic [COND_W-1:0] COND_OFF       = 3'd0;
	localparam logic [COND_W-1:0] COND_VERY_DRY  = 3'd1;
	localparam logic [COND_W-1:0] COND_DRY       = 3'd2;
	localparam logic [COND_W-1:0] COND_IDLE      = 3'd3;
	localparam logic [COND_W-1:0] COND_MOIST     = 3'd4;
	localparam logic [COND_W-1:0] COND_WET       = 3'd5;
	localparam logic [COND_W-1:0] COND_SUBMERGED = 3'd6;
	localparam logic [COND_W-1:0] COND_BAD_CAL   = 3'd7;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/soil_moisture_classifier.sv =====
// An accepted request moves through SETUP, DIV and DONE; an inactive request or
// equal dry and wet readings skip DIV. DONE loads the result register once it is
// empty or not stalled. A new request is taken only after that load; DIV runs the
// 9-step bit-serial restoring divider.
// Reset (arst_n low, asynchronous) loads the register defaults, stops the dry
// timer, clears the start time and clears the result valid flag.
`default_nettype none
`include "assert_macros.svh"

module soil_moisture_classifier
	import smc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data,
	// Request channel
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   active,
	input  wire logic [SAMPLE_BITS-1:0] adc_sample,
	input  wire logic [TIME_BITS-1:0]   now_ms,
	// Result channel
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [PCT_W-1:0]            moisture_percent,
	output logic [COND_W-1:0]           condition,
	output logic                        alarm_on
);

	localparam int NUM_W     = SAMPLE_BITS + PCT_W;
	localparam int DSH_W     = SAMPLE_BITS + QUOT_W - 1;
	localparam int DIV_STEPS = QUOT_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

	// Configuration registers
	logic [SAMPLE_BITS-1:0] dry_q;
	logic [SAMPLE_BITS-1:0] wet_q;
	logic [CFG_W-1:0]       delay_q;

	// Sequencer and timer state
	state_t                 state_q;
	state_t                 state_d;
	logic [CNT_W-1:0]       cnt_q;
	logic                   running_q;
	logic [TIME_BITS-1:0]   start_q;
	logic                   out_valid_q;

	// Latched request
	logic                   active_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [TIME_BITS-1:0]   now_q;

	// Divider datapath
	logic                   bad_cal_q;
	logic                   q_neg_q;
	logic [NUM_W-1:0]       rem_q;
	logic [DSH_W-1:0]       dsh_q;
	logic [QUOT_W-1:0]      quot_q;

	// Result register
	logic [PCT_W-1:0]       pct_q;
	logic [COND_W-1:0]      cond_q;
	logic                   alarm_q;

	// Combinational signals
	logic                   in_acc;
	logic                   load_out;
	logic                   skip_div;
	logic [SAMPLE_BITS:0]   num_diff;
	logic [SAMPLE_BITS:0]   den_diff;
	logic [SAMPLE_BITS-1:0] num_abs;
	logic [SAMPLE_BITS-1:0] den_abs;
	logic [NUM_W-1:0]       num_ext;
	logic [NUM_W-1:0]       num_mag;
	logic                   div_ge;
	logic [PCT_W-1:0]       pct_d;
	logic [COND_W-1:0]      cond_d;
	logic                   alarm_d;
	logic                   dry_band;
	logic [TIME_BITS-1:0]   start_eff;
	logic [TIME_BITS-1:0]   elapsed;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign skip_div = !active_q || (dry_q == wet_q);

	// Signed numerator and denominator split into sign and magnitude.
	assign num_diff = {1'b0, sample_q} - {1'b0, wet_q};
	assign den_diff = {1'b0, dry_q} - {1'b0, wet_q};
	assign num_abs  = num_diff[SAMPLE_BITS] ? SAMPLE_BITS'(-num_diff)
	                                        : num_diff[SAMPLE_BITS-1:0];
	assign den_abs  = den_diff[SAMPLE_BITS] ? SAMPLE_BITS'(-den_diff)
	                                        : den_diff[SAMPLE_BITS-1:0];
	assign num_ext  = NUM_W'(num_abs);
	// Times 100 as 64 + 32 + 4.
	assign num_mag  = (num_ext << 6) + (num_ext << 5) + (num_ext << 2);

	// One restoring step: compare against the divisor shifted into place.
	assign div_ge = (DSH_W'(rem_q) >= dsh_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = skip_div ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Clamp the quotient into a percentage and classify it.
	always_comb begin
		if (q_neg_q) begin
			pct_d = PCT_FULL;
		end else if (quot_q > QUOT_W'(PCT_FULL)) begin
			pct_d = PCT_ZERO;
		end else begin
			pct_d = PCT_FULL - quot_q[PCT_W-1:0];
		end

		dry_band = 1'b0;
		alarm_d  = 1'b0;
		if (!active_q) begin
			pct_d  = PCT_ZERO;
			cond_d = COND_OFF;
		end else if (bad_cal_q) begin
			pct_d  = PCT_ZERO;
			cond_d = COND_BAD_CAL;
		end else if (pct_d < PCT_DRY) begin
			dry_band = 1'b1;
			cond_d   = (pct_d < PCT_VERY_DRY) ? COND_VERY_DRY : COND_DRY;
		end else if (pct_d <= PCT_IDLE_MAX) begin
			cond_d = COND_IDLE;
		end else if (pct_d <= PCT_MOIST_MAX) begin
			cond_d = COND_MOIST;
		end else if (pct_d <= PCT_WET_MAX) begin
			cond_d = COND_WET;
		end else begin
			cond_d  = COND_SUBMERGED;
			alarm_d = 1'b1;
		end

		// Dry delay measured from the stored start, or from now if just starting.
		start_eff = running_q ? start_q : now_q;
		elapsed   = now_q - start_eff;
		if (dry_band) alarm_d = (CMP_W'(elapsed) >= CMP_W'(delay_q));
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_q   <= SAMPLE_BITS'(DRY_READING_RESET);
			wet_q   <= '0;
			delay_q <= DRY_DELAY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DRY_READING: dry_q   <= cfg_data[SAMPLE_BITS-1:0];
				REG_WET_READING: wet_q   <= cfg_data[SAMPLE_BITS-1:0];
				REG_DRY_DELAY:   delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			running_q   <= 1'b0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SETUP) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				running_q   <= dry_band;
				if (dry_band && !running_q) start_q <= now_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request latch, divider and result registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			active_q <= active;
			sample_q <= adc_sample;
			now_q    <= now_ms;
		end
		if (state_q == ST_SETUP) begin
			bad_cal_q <= (dry_q == wet_q);
			q_neg_q   <= num_diff[SAMPLE_BITS] ^ den_diff[SAMPLE_BITS];
			rem_q     <= num_mag;
			dsh_q     <= {den_abs, (QUOT_W - 1)'(0)};
			quot_q    <= '0;
		end else if (state_q == ST_DIV) begin
			if (div_ge) rem_q <= NUM_W'(DSH_W'(rem_q) - dsh_q);
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QUOT_W-2:0], div_ge};
		end
		if (load_out) begin
			pct_q   <= pct_d;
			cond_q  <= cond_d;
			alarm_q <= alarm_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign moisture_percent = pct_q;
	assign condition        = cond_q;
	assign alarm_on         = alarm_q;

	// Checks
	`ASSERT_NEXT(a_accept_setup, clk, arst_n, in_acc, state_q == ST_SETUP)
	`ASSERT_IMPL(a_div_count, clk, arst_n, state_q == ST_DIV, cnt_q < CNT_W'(DIV_STEPS))
	`ASSERT_IMPL(a_pct_range, clk, arst_n, out_valid, moisture_percent <= PCT_FULL)
	`ASSERT_IMPL(a_off_quiet, clk, arst_n, out_valid && (condition == COND_OFF),
		(moisture_percent == PCT_ZERO) && !alarm_on)
	`ASSERT_IMPL(a_submerged_alarm, clk, arst_n,
		out_valid && (condition == COND_SUBMERGED), alarm_on)

endmodule

`default_nettype wire
